// ===== hdl/integer_to_english_word_tokens_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer to English words block
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing in synthesis. The using module must have clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ENGLISH_WORD_TOKENS_ASSERT_SVH
`define INTEGER_TO_ENGLISH_WORD_TOKENS_ASSERT_SVH

`ifndef SYNTHESIS
// Check that prop holds at every edge outside reset.
`define I2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that post holds in the cycle after pre.
`define I2E_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define I2E_ASSERT(lbl, prop, msg)
`define I2E_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== hdl/i2e_pkg.sv =====
// ----------------------------------------------------------------------------
// i2e_pkg
// Widths, word codes and the converter-to-speller handoff type.
// ----------------------------------------------------------------------------
package i2e_pkg;

  localparam int VALUE_W    = 31;
  localparam int WORD_W     = 5;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SHIFT_CNT_W = $clog2(VALUE_W + 1);

  // Word codes
  localparam logic [WORD_W-1:0] W_ZERO       = 5'd0;
  localparam logic [WORD_W-1:0] W_TEN        = 5'd10;
  localparam logic [WORD_W-1:0] W_TENS_BASE  = 5'd18;  // Twenty is code 20 for tens digit 2
  localparam logic [WORD_W-1:0] W_HUNDRED    = 5'd28;
  localparam logic [WORD_W-1:0] W_SCALE_BASE = 5'd28;  // Thousand is code 29 for group 1

  typedef struct packed {
    logic             valid;
    logic [BCD_W-1:0] digits;
  } i2e_bcd_t;

endpackage

// ===== hdl/i2e_if.sv =====
// ----------------------------------------------------------------------------
// i2e channel interfaces
// Valid/ready channels for the input number and the output word tokens.
// ----------------------------------------------------------------------------
interface i2e_in_if;
  import i2e_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2e_out_if;
  import i2e_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_code;
  logic              last_word;
  modport source (output valid, output word_code, output last_word, input ready);
  modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

// ===== hdl/i2e_bcd.sv =====
// ----------------------------------------------------------------------------
// i2e_bcd
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
`include "integer_to_english_word_tokens_assert.svh"

module i2e_bcd
  import i2e_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  i2e_in_if.sink       din,
  output i2e_bcd_t     res,
  input  logic         res_ready
);

  typedef enum logic [1:0] {IDLE, SHIFT, HOLD} state_t;

  state_t                 state;
  logic [VALUE_W-1:0]     bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       adj;
  logic [SHIFT_CNT_W-1:0] cnt;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign din.ready  = (state == IDLE);
  assign res.valid  = (state == HOLD);
  assign res.digits = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (din.valid) begin
            bin   <= din.value;
            bcd   <= '0;
            cnt   <= '0;
            state <= SHIFT;
          end
        end
        SHIFT: begin
          bcd <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == SHIFT_CNT_W'(VALUE_W - 1)) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `I2E_ASSERT(a_hold_after_all_bits, (state != HOLD) || (cnt == SHIFT_CNT_W'(VALUE_W)), "conversion ended early")
  `I2E_ASSERT_NEXT(a_handoff_frees, (state == HOLD) && res_ready, state == IDLE, "converter held after handoff")

endmodule

// ===== hdl/i2e_speller.sv =====
// ----------------------------------------------------------------------------
// i2e_speller
// Walks the BCD digits a group of three at a time and emits word tokens.
// ----------------------------------------------------------------------------
`include "integer_to_english_word_tokens_assert.svh"

module i2e_speller
  import i2e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  i2e_bcd_t  bcd,
  output logic      bcd_ready,
  i2e_out_if.source dout
);

  localparam int DIG_W = 48;  // four groups of three digits

  typedef enum logic [2:0] {IDLE, ZERO, HDIG, HWORD, TENS, UNITS, SCALE} state_t;

  state_t             state;
  logic [DIG_W-1:0]   dig;
  logic [1:0]         grp;
  logic               ovalid;
  logic [WORD_W-1:0]  ocode;
  logic               olast;

  logic [3:0] d2, d1, d0;
  logic       grp_zero, rest_zero, tail_none, take, emit;

  assign d2        = dig[47:44];
  assign d1        = dig[43:40];
  assign d0        = dig[39:36];
  assign grp_zero  = (dig[47:36] == '0);
  assign rest_zero = (dig[35:0] == '0);
  assign tail_none = (grp == 2'd0) && rest_zero;
  assign take      = !ovalid || dout.ready;

  // The current state has a word to put out (skipped parts have none)
  always_comb begin
    unique case (state)
      ZERO:    emit = 1'b1;
      HDIG:    emit = !grp_zero && (d2 != 4'd0);
      HWORD:   emit = 1'b1;
      TENS:    emit = (d1 != 4'd0);
      UNITS:   emit = (d0 != 4'd0);
      SCALE:   emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  assign bcd_ready      = (state == IDLE);
  assign dout.valid     = ovalid;
  assign dout.word_code = ocode;
  assign dout.last_word = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      ovalid <= 1'b0;
      grp    <= '0;
    end else begin
      // Load a new word when one is put out, otherwise hold until taken
      ovalid <= (emit && take) || (ovalid && !dout.ready);
      unique case (state)
        IDLE: begin
          if (bcd.valid) begin
            dig   <= {{(DIG_W - BCD_W){1'b0}}, bcd.digits};
            grp   <= 2'd3;
            state <= (bcd.digits == '0) ? ZERO : HDIG;
          end
        end
        ZERO: begin
          if (take) begin
            ocode  <= W_ZERO;
            olast  <= 1'b1;
            state  <= IDLE;
          end
        end
        HDIG: begin
          if (grp_zero) begin
            if (grp == 2'd0) begin
              state <= IDLE;
            end else begin
              dig <= {dig[DIG_W-13:0], 12'b0};
              grp <= grp - 1'b1;
            end
          end else if (d2 == 4'd0) begin
            state <= TENS;
          end else if (take) begin
            ocode  <= {1'b0, d2};
            olast  <= 1'b0;
            state  <= HWORD;
          end
        end
        HWORD: begin
          if (take) begin
            ocode  <= W_HUNDRED;
            olast  <= (d1 == 4'd0) && (d0 == 4'd0) && tail_none;
            state  <= TENS;
          end
        end
        TENS: begin
          if (d1 == 4'd0) begin
            state <= UNITS;
          end else if (take) begin
            if (d1 == 4'd1) begin
              ocode <= W_TEN + {1'b0, d0};
              olast <= tail_none;
              state <= (grp == 2'd0) ? IDLE : SCALE;
            end else begin
              ocode <= W_TENS_BASE + {1'b0, d1};
              olast <= (d0 == 4'd0) && tail_none;
              state <= UNITS;
            end
          end
        end
        UNITS: begin
          if (d0 == 4'd0) begin
            state <= (grp == 2'd0) ? IDLE : SCALE;
          end else if (take) begin
            ocode  <= {1'b0, d0};
            olast  <= tail_none;
            state  <= (grp == 2'd0) ? IDLE : SCALE;
          end
        end
        SCALE: begin
          if (take) begin
            ocode  <= W_SCALE_BASE + {3'b0, grp};
            olast  <= rest_zero;
            dig    <= {dig[DIG_W-13:0], 12'b0};
            grp    <= grp - 1'b1;
            state  <= HDIG;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `I2E_ASSERT(a_scale_not_units, (state != SCALE) || (grp != 2'd0), "scale word for units group")
  `I2E_ASSERT(a_hundred_has_digit, (state != HWORD) || (d2 != 4'd0), "Hundred without digit")

endmodule

// ===== hdl/integer_to_english_word_tokens.sv =====
// ----------------------------------------------------------------------------
// integer_to_english_word_tokens
// Spells a 31-bit unsigned integer as a run of English word codes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                     | notes
//  din     | in  | value[30:0]                 | one number per item
//  dout    | out | word_code[4:0], last_word   | one word per item, 1..16 per number
//
//  A number is converted to ten BCD digits one bit a cycle by the bit-serial
//  converter, which loads it, shifts in every bit and holds the result until
//  the speller takes it. The speller then emits one word a cycle while dout
//  takes them and steps past each skipped part; it spells while the next number
//  converts. Reset (rst, synchronous) empties both stages and the output
//  register. A stall on dout holds the output word and the speller; din then
//  backs up once the converter has a finished number waiting.
// ----------------------------------------------------------------------------
module integer_to_english_word_tokens
  import i2e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2e_in_if.sink    din,
  i2e_out_if.source dout
);

  // Handoff of one converted number from the converter to the speller
  i2e_bcd_t bcd;
  logic     bcd_ready;

  // Binary to decimal, one bit a cycle
  i2e_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .res       (bcd),
    .res_ready (bcd_ready)
  );

  // Decimal digits to word tokens, one word a cycle while dout takes them, through the output register
  i2e_speller u_speller (
    .clk       (clk),
    .rst       (rst),
    .bcd       (bcd),
    .bcd_ready (bcd_ready),
    .dout      (dout)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for integer_to_english_word_tokens
// Offers numbers on din and checks every word that comes out on dout against
// a spelling worked out inside the bench when the number is taken. A directed
// set covers zero, the teens, the tens, hundreds, zero groups and the largest
// value. Random numbers follow, half built group by group so that zero groups,
// teens and round hundreds turn up often. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import i2e_pkg::*;

  // One spoken word as it should leave the block
  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              last;
  } spoken_word_t;

  localparam int CYCLE_LIMIT        = 600000;
  localparam int RANDOM_PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES      = 64;   // well past one conversion and a full spelling
  localparam int LONG_HOLD_CYCLES   = 600;
  localparam int LONG_HOLD_AT_WORD  = 300;
  localparam int MAX_GAP            = 14;

  logic clk;
  logic rst;

  i2e_in_if  number_if ();
  i2e_out_if word_if ();

  integer_to_english_word_tokens i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (number_if),
    .dout (word_if)
  );

  // Numbers waiting to be offered, and words still owed by the block
  logic [VALUE_W-1:0] number_q [$];
  spoken_word_t       spoken_q [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  logic number_taken  = 1'b0;  // din handshake at the last rising edge
  logic word_taken    = 1'b0;  // dout handshake at the last rising edge

  int unsigned directed_values [25] = '{
    0, 1, 9, 10, 11, 15, 19, 20, 21, 45, 90, 99, 100, 101, 110, 119, 999,
    1000, 1001, 1000010, 1000000, 1000000000, 1111111111, 2147483647, 1999999999
  };

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst                 = 1'b1;
    number_if.valid     = 1'b0;
    number_if.value     = '0;
    word_if.ready       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Spelling predictor: append the words of one number to spoken_q
  // --------------------------------------------------------------------------
  function automatic void spell_number(input logic [VALUE_W-1:0] value);
    logic [WORD_W-1:0] words [$];
    int unsigned       groups [4];
    int unsigned       rest;
    int unsigned       grp;
    int unsigned       below;
    spoken_word_t      w;

    if (value == '0) begin
      words.push_back(W_ZERO);
    end else begin
      rest = value;
      for (int s = 0; s < 4; s++) begin
        groups[s] = rest % 1000;
        rest      = rest / 1000;
      end
      // Most significant group first; an all-zero group says nothing at all
      for (int s = 3; s >= 0; s--) begin
        grp = groups[s];
        if (grp != 0) begin
          if (grp >= 100) begin
            words.push_back(WORD_W'(grp / 100));
            words.push_back(W_HUNDRED);
          end
          below = grp % 100;
          if (below >= 20) begin
            words.push_back(W_TENS_BASE + WORD_W'(below / 10));
            if (below % 10 != 0)
              words.push_back(WORD_W'(below % 10));
          end else if (below != 0) begin
            // One..Nineteen share their code with their value
            words.push_back(WORD_W'(below));
          end
          if (s > 0)
            words.push_back(W_SCALE_BASE + WORD_W'(s));
        end
      end
    end

    foreach (words[k]) begin
      w.code = words[k];
      w.last = (k == words.size() - 1);
      spoken_q.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random numbers: half of them built from three-digit groups so that zero groups,
  // teens, round tens and round hundreds come up far more than by chance
  // --------------------------------------------------------------------------
  function automatic int unsigned random_group();
    int unsigned g;
    case ($urandom_range(0, 4))
      0:       g = 0;
      1:       g = $urandom_range(1, 999);
      2:       g = $urandom_range(0, 9) * 100 + $urandom_range(10, 19);
      3:       g = $urandom_range(1, 9) * 100;
      default: g = $urandom_range(0, 9) * 100 + $urandom_range(1, 9) * 10;
    endcase
    return g;
  endfunction

  function automatic logic [VALUE_W-1:0] make_number();
    longint unsigned v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 999);
      2:       v = $urandom >> $urandom_range(1, 31);
      default: begin
        v = longint'($urandom_range(0, 2)) * 1000000000
          + longint'(random_group()) * 1000000
          + longint'(random_group()) * 1000
          + longint'(random_group());
        // Drop back a billion when the top group overshoots the range
        if (v > 64'd2147483647)
          v = v - 64'd1000000000;
      end
    endcase
    return v[VALUE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line each, all counted
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Number driver: hold an item until taken, then wait its drawn gap
  // --------------------------------------------------------------------------
  int   send_gap   = 0;
  logic send_burst = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      number_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!number_if.valid || number_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        number_if.valid <= 1'b0;
      end else if (number_q.size() != 0) begin
        number_if.valid <= 1'b1;
        number_if.value <= number_q.pop_front();
        // Now and then switch between idling and back-to-back items
        if ($urandom_range(0, 39) == 0)
          send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        number_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold: once, after a few hundred words, count down a long stretch
  // during which the sink takes nothing, so that the block fills up and
  // pushes back on din while numbers are still being offered
  // --------------------------------------------------------------------------
  int hold_left  = 0;
  int words_seen = 0;

  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (word_if.valid && word_if.ready) begin
      words_seen++;
      if (words_seen == LONG_HOLD_AT_WORD)
        hold_left = LONG_HOLD_CYCLES;
    end
  end

  // --------------------------------------------------------------------------
  // Word sink: stall a drawn number of cycles after each word, and hold off
  // entirely while the long hold runs
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  logic take_burst = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      word_if.ready <= 1'b0;
    end else begin
      if (word_taken) begin
        if ($urandom_range(0, 39) == 0)
          take_burst = !take_burst;
        stall_left = take_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        word_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        word_if.ready <= 1'b0;
      end else begin
        word_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every number taken, check every word taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    spoken_word_t want;
    if (rst) begin
      number_taken <= 1'b0;
      word_taken   <= 1'b0;
    end else begin
      number_taken <= number_if.valid && number_if.ready;
      word_taken   <= word_if.valid && word_if.ready;
      if (number_if.valid && number_if.ready)
        spell_number(number_if.value);
      if (word_if.valid && word_if.ready) begin
        if (spoken_q.size() == 0) begin
          report_mismatch($sformatf("word %0d with no word owed", word_if.word_code));
        end else begin
          want = spoken_q.pop_front();
          if (word_if.word_code !== want.code)
            report_mismatch($sformatf("word_code %0d, wanted %0d",
                                      word_if.word_code, want.code));
          if (word_if.last_word !== want.last)
            report_mismatch($sformatf("last_word %0b, wanted %0b on word %0d",
                                      word_if.last_word, want.last, want.code));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Block the caller until every number is taken and every word has come
  task automatic wait_until_spoken();
    do
      @(posedge clk);
    while (number_q.size() != 0 || number_if.valid || spoken_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed set, then two random phases with a full drain between
  // --------------------------------------------------------------------------
  initial begin : stimulus
    do
      @(posedge clk);
    while (rst);

    foreach (directed_values[k])
      number_q.push_back(directed_values[k][VALUE_W-1:0]);
    wait_until_spoken();

    repeat (RANDOM_PHASE_ITEMS)
      number_q.push_back(make_number());
    wait_until_spoken();

    // Sender has paused until the block went quiet; start the second phase
    repeat (RANDOM_PHASE_ITEMS)
      number_q.push_back(make_number());
    wait_until_spoken();

    // Catch any stray word after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && spoken_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
